// ===== hw/rtl/rshf_pkg.sv =====
// Shared types and constants for the removable storage health tracker.
// No dependencies; imported by the csr interface and all rtl modules.
package rshf_pkg;

   // volume states
   typedef enum logic [1:0] {
      ST_ABSENT  = 2'd0,
      ST_READY   = 2'd1,
      ST_FAULTED = 2'd2
   } storage_state_type;

   // request operation codes
   localparam logic [1:0] OP_IO_REPORT = 2'd0;
   localparam logic [1:0] OP_PROBE     = 2'd1;
   localparam logic [1:0] OP_TIME      = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAIL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROBE_INTERVAL = 2'd1;

   // register reset values
   localparam logic [7:0]  FAIL_THRESHOLD_RESET = 8'd1;
   localparam logic [31:0] PROBE_INTERVAL_RESET = 32'd1000;

   // failure run saturation
   localparam logic [7:0] RUN_MAX = 8'hFF;

   // tracker state apart from the event counters
   typedef struct packed {
      storage_state_type cur_state;
      logic [7:0]        failure_run;
      logic [31:0]       last_probe_time;
      logic              first_probe_pending;
   } track_state_type;

   // per-beat flags from the update logic
   typedef struct packed {
      logic event_res;
      logic probe_due;
      logic mount_inc;
      logic fault_inc;
   } step_flags_type;

endpackage

// ===== hw/rtl/rshf_if.sv =====
// Valid/ready channel interfaces for request, response and csr write beats.
// Depends on rshf_pkg.
interface rshf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic        io_ok;
   logic        card_present;
   logic        mount_ok;

   modport source (output valid, op, now_ms, io_ok, card_present, mount_ok, input ready);
   modport sink (input valid, op, now_ms, io_ok, card_present, mount_ok, output ready);
endinterface

interface rshf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  storage_state;
   logic        event_res;
   logic        probe_due;
   logic [31:0] mount_count;
   logic [31:0] fault_count;

   modport source (output valid, storage_state, event_res, probe_due, mount_count,
                   fault_count, input ready);
   modport sink (input valid, storage_state, event_res, probe_due, mount_count,
                 fault_count, output ready);
endinterface

interface rshf_csr_if;
   import rshf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rshf_step.sv =====
// Next-state logic of the health tracker for one request beat.
// Depends on rshf_pkg; instantiated by removable_storage_health_fsm_core.
module rshf_step (
   input  rshf_pkg::track_state_type cur,
   input  logic [1:0]                op,
   input  logic [31:0]               now_ms,
   input  logic                      io_ok,
   input  logic                      card_present,
   input  logic                      mount_ok,
   input  logic [7:0]                fault_limit,
   input  logic [31:0]               probe_interval,
   output rshf_pkg::track_state_type nxt,
   output rshf_pkg::step_flags_type  flags
);
   import rshf_pkg::*;

   logic [31:0] elapsed;
   logic [7:0]  thr;
   logic [7:0]  run_inc;

   assign elapsed = now_ms - cur.last_probe_time;
   assign thr     = (fault_limit == 8'd0) ? 8'd1 : fault_limit;
   assign run_inc = (cur.failure_run == RUN_MAX) ? RUN_MAX : cur.failure_run + 8'd1;

   // state update and event flags
   always_comb begin
      nxt             = cur;
      flags.event_res = 1'b0;
      flags.mount_inc = 1'b0;
      flags.fault_inc = 1'b0;
      flags.probe_due = (cur.cur_state != ST_READY) &&
                        (cur.first_probe_pending || (elapsed >= probe_interval));
      case (op)
         OP_IO_REPORT: begin
            if (cur.cur_state == ST_READY) begin
               if (io_ok) begin
                  nxt.failure_run = 8'd0;
               end else begin
                  nxt.failure_run = run_inc;
                  if (run_inc >= thr) begin
                     nxt.cur_state   = ST_FAULTED;
                     flags.fault_inc = 1'b1;
                     flags.event_res = 1'b1;
                  end
               end
            end
         end
         OP_PROBE: begin
            nxt.last_probe_time     = now_ms;
            nxt.first_probe_pending = 1'b0;
            nxt.failure_run         = 8'd0;
            if (card_present && mount_ok) begin
               nxt.cur_state   = ST_READY;
               flags.mount_inc = (cur.cur_state != ST_READY);
            end else begin
               nxt.cur_state = ST_ABSENT;
            end
            flags.event_res = (nxt.cur_state != cur.cur_state);
         end
         default: begin
            // time check only
         end
      endcase
   end

endmodule

// ===== hw/rtl/removable_storage_health_fsm_core.sv =====
// Top level of the removable storage health tracker.
// Depends on rshf_pkg, rshf_if and rshf_step.
//
// Tracks a removable volume as absent, ready or faulted from a stream of I/O
// outcome, probe outcome and time check beats, and returns one response beat
// per request with the new state, an event flag, whether a probe was due
// before the beat, and the mount and fault totals. Throughput is one request
// per clock while the response side does not stall; each response appears in
// the cycle after its request is taken, from the registered status record and
// the response register. A held response does not block the next request
// while the response side accepts it in the same cycle. Counters are COUNT_WIDTH
// bits wide and the response shows their low 32 bits. Csr writes are always taken.
module removable_storage_health_fsm_core #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input logic   clock,
   input logic   reset,
   rshf_req_if.sink   req,
   rshf_rsp_if.source rsp,
   rshf_csr_if.sink   csr
);
   import rshf_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   track_state_type        state_ff;
   track_state_type        state_in;
   step_flags_type         flags;
   logic [COUNT_WIDTH-1:0] mounts_ff;
   logic [COUNT_WIDTH-1:0] mounts_in;
   logic [COUNT_WIDTH-1:0] faults_ff;
   logic [COUNT_WIDTH-1:0] faults_in;
   logic [7:0]             fault_limit_ff;
   logic [31:0]            probe_interval_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_state_ff;
   logic                   rsp_event_ff;
   logic                   rsp_due_ff;
   logic [31:0]            rsp_mounts_ff;
   logic [31:0]            rsp_faults_ff;
   logic                   req_accept;

   // handshakes
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;
   assign csr.ready  = 1'b1;

   // per-beat update
   rshf_step u_step (
      .cur            (state_ff),
      .op             (req.op),
      .now_ms         (req.now_ms),
      .io_ok          (req.io_ok),
      .card_present   (req.card_present),
      .mount_ok       (req.mount_ok),
      .fault_limit    (fault_limit_ff),
      .probe_interval (probe_interval_ff),
      .nxt            (state_in),
      .flags          (flags)
   );

   assign mounts_in = flags.mount_inc ? mounts_ff + COUNT_ONE : mounts_ff;
   assign faults_in = flags.fault_inc ? faults_ff + COUNT_ONE : faults_ff;

   // control state, counters and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cur_state           <= ST_ABSENT;
         state_ff.failure_run         <= 8'd0;
         state_ff.last_probe_time     <= 32'd0;
         state_ff.first_probe_pending <= 1'b1;
         mounts_ff                    <= '0;
         faults_ff                    <= '0;
         fault_limit_ff               <= FAIL_THRESHOLD_RESET;
         probe_interval_ff            <= PROBE_INTERVAL_RESET;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_FAIL_THRESHOLD: fault_limit_ff <= csr.data[7:0];
               CSR_PROBE_INTERVAL: probe_interval_ff <= csr.data[31:0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            state_ff     <= state_in;
            mounts_ff    <= mounts_in;
            faults_ff    <= faults_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_state_ff  <= state_in.cur_state;
         rsp_event_ff  <= flags.event_res;
         rsp_due_ff    <= flags.probe_due;
         rsp_mounts_ff <= 32'(mounts_in);
         rsp_faults_ff <= 32'(faults_in);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.storage_state = rsp_state_ff;
   assign rsp.event_res     = rsp_event_ff;
   assign rsp.probe_due     = rsp_due_ff;
   assign rsp.mount_count   = rsp_mounts_ff;
   assign rsp.fault_count   = rsp_faults_ff;

   // ready is entered only through a probe beat
   a_ready_needs_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cur_state != ST_READY && !(req_accept && req.op == OP_PROBE))
      |=> (state_ff.cur_state != ST_READY))
      else $error("entered ready without a probe beat");

   // fault total moves only with entry into faulted
   a_fault_count_entry: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(faults_ff)) |-> (state_ff.cur_state == ST_FAULTED))
      else $error("fault total changed outside entry into faulted");

   // every accepted request leaves a response pending
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule
